// ===== rtl/r50fp_pkg.sv =====
// ----------------------------------------------------------------------------
// RAD50 file-name packer package
// Shared types, character constants and the RAD50 code mapping.
// ----------------------------------------------------------------------------
`default_nettype none

package r50fp_pkg;

  // Collection phase of the current path component
  typedef enum logic [1:0] {
    PH_NAME   = 2'd0,
    PH_EXT    = 2'd1,
    PH_DONE   = 2'd2,
    PH_UNUSED = 2'd3
  } phase_e;

  localparam int unsigned NameLen = 6;
  localparam int unsigned ExtLen  = 3;

  typedef logic [5:0]  code_t;
  typedef logic [15:0] word_t;

  localparam logic [7:0] ChEnd   = 8'h00;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChAllOn = 8'hFF;

  localparam logic [6:0] ChSpace  = 7'h20;
  localparam logic [6:0] ChDollar = 7'h24;
  localparam logic [6:0] ChDot7   = 7'h2E;
  localparam logic [6:0] ChDig0   = 7'h30;
  localparam logic [6:0] ChDig9   = 7'h39;
  localparam logic [6:0] ChUpA    = 7'h41;
  localparam logic [6:0] ChUpZ    = 7'h5A;
  localparam logic [6:0] ChLoA    = 7'h61;
  localparam logic [6:0] ChLoZ    = 7'h7A;

  localparam code_t CodeSpace  = 6'd0;
  localparam code_t CodeAlpha  = 6'd1;
  localparam code_t CodeDollar = 6'd27;
  localparam code_t CodeDot    = 6'd28;
  localparam code_t CodeOther  = 6'd29;
  localparam code_t CodeDigit  = 6'd30;

  localparam word_t WeightA = 16'd1600;
  localparam word_t WeightB = 16'd40;

  // Map one byte to its RAD50 code; the top bit is ignored except for 0xFF
  function automatic code_t rad_code(input logic [7:0] b);
    logic [6:0] c;
    code_t      r;
    c = b[6:0];
    if (b == ChAllOn) begin
      r = CodeSpace;
    end else if (c == ChSpace) begin
      r = CodeSpace;
    end else if (c == ChDollar) begin
      r = CodeDollar;
    end else if (c == ChDot7) begin
      r = CodeDot;
    end else if (c >= ChDig0 && c <= ChDig9) begin
      r = CodeDigit + code_t'(c - ChDig0);
    end else if (c >= ChUpA && c <= ChUpZ) begin
      r = CodeAlpha + code_t'(c - ChUpA);
    end else if (c >= ChLoA && c <= ChLoZ) begin
      r = CodeAlpha + code_t'(c - ChLoA);
    end else begin
      r = CodeOther;
    end
    return r;
  endfunction

  // Pack three codes into one word: 1600*a + 40*b + c (max 63999)
  function automatic word_t pack3(input code_t a, input code_t b, input code_t c);
    return word_t'(word_t'(a) * WeightA) + word_t'(word_t'(b) * WeightB) + word_t'(c);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rad50_filename_packer_unit.sv =====
// ----------------------------------------------------------------------------
// RAD50 file-name packer
// Packs the last component of a byte-serial path into three RAD50 words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / name_byte_i) carries one path
//   byte per beat. A slash drops everything kept so far; a zero byte ends
//   the name and produces one result beat. Other bytes produce nothing.
//   Output channel (out_valid_o / out_stall_i) carries name_word_first_o,
//   name_word_second_o and ext_word_o.
//   Throughput: one byte per cycle while the input is not stalled. The
//   per-byte state update (RAD50 lookup plus counter step) and the word
//   packing are both combinational. The result appears in the output
//   register in the cycle after the zero byte is accepted.
//   Stall: the result register holds while out_stall_i is high; the input
//   stalls only while that full register is itself stalled.
//   Reset: rst_ni clears phase, counters, kept codes and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module rad50_filename_packer_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  name_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      name_word_first_o,
  output logic [15:0]      name_word_second_o,
  output logic [15:0]      ext_word_o
);

  // Name and extension lengths are fixed by the three-word result format
  localparam int unsigned NameLen = r50fp_pkg::NameLen;
  localparam int unsigned ExtLen  = r50fp_pkg::ExtLen;

  localparam int unsigned NcW = $clog2(NameLen + 1);
  localparam int unsigned EcW = $clog2(ExtLen + 1);
  localparam int unsigned NiW = (NameLen > 1) ? $clog2(NameLen) : 1;
  localparam int unsigned EiW = (ExtLen > 1) ? $clog2(ExtLen) : 1;

  // Collection state
  r50fp_pkg::phase_e phase_q, phase_d;
  logic [NcW-1:0]    name_cnt_q, name_cnt_d;
  logic [EcW-1:0]    ext_cnt_q, ext_cnt_d;
  r50fp_pkg::code_t  name_codes_q [NameLen];
  r50fp_pkg::code_t  name_codes_d [NameLen];
  r50fp_pkg::code_t  ext_codes_q  [ExtLen];
  r50fp_pkg::code_t  ext_codes_d  [ExtLen];

  // Result register
  logic              out_valid_q, out_valid_d;
  r50fp_pkg::word_t  word_first_q, word_second_q, word_ext_q;

  logic              in_acc;
  logic              is_end, is_slash, is_dot;
  r50fp_pkg::code_t  code;

  // Stall the input only while a finished result is held back downstream
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  assign is_end   = (name_byte_i == r50fp_pkg::ChEnd);
  assign is_slash = (name_byte_i == r50fp_pkg::ChSlash);
  assign is_dot   = (name_byte_i == r50fp_pkg::ChDot);
  assign code     = r50fp_pkg::rad_code(name_byte_i);

  // Next collection state
  always_comb begin
    phase_d     = phase_q;
    name_cnt_d  = name_cnt_q;
    ext_cnt_d   = ext_cnt_q;
    name_codes_d = name_codes_q;
    ext_codes_d  = ext_codes_q;

    if (in_acc) begin
      if (is_end || is_slash) begin
        // Drop everything kept for this component
        phase_d    = r50fp_pkg::PH_NAME;
        name_cnt_d = '0;
        ext_cnt_d  = '0;
        for (int i = 0; i < NameLen; i++) name_codes_d[i] = '0;
        for (int i = 0; i < ExtLen; i++)  ext_codes_d[i]  = '0;
      end else begin
        unique case (phase_q)
          r50fp_pkg::PH_NAME: begin
            priority if (name_cnt_q == '0) begin
              // First name byte is kept even when it is a dot
              name_codes_d[0] = code;
              name_cnt_d      = NcW'(1);
            end else if (is_dot) begin
              phase_d = r50fp_pkg::PH_EXT;
            end else if (name_cnt_q < NcW'(NameLen)) begin
              name_codes_d[name_cnt_q[NiW-1:0]] = code;
              name_cnt_d = name_cnt_q + NcW'(1);
            end else begin
              // Name full: this byte opens the extension
              ext_codes_d[0] = code;
              ext_cnt_d      = EcW'(1);
              phase_d = (ExtLen <= 1) ? r50fp_pkg::PH_DONE : r50fp_pkg::PH_EXT;
            end
          end
          r50fp_pkg::PH_EXT: begin
            priority if (ext_cnt_q != '0 && is_dot) begin
              phase_d = r50fp_pkg::PH_DONE;
            end else if (ext_cnt_q < EcW'(ExtLen)) begin
              ext_codes_d[ext_cnt_q[EiW-1:0]] = code;
              ext_cnt_d = ext_cnt_q + EcW'(1);
              if (ext_cnt_q + EcW'(1) >= EcW'(ExtLen)) phase_d = r50fp_pkg::PH_DONE;
            end else begin
              phase_d = r50fp_pkg::PH_DONE;
            end
          end
          default: begin
            // Finished extension (and the unused code): ignore the byte
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= r50fp_pkg::PH_NAME;
      name_cnt_q <= '0;
      ext_cnt_q  <= '0;
      for (int i = 0; i < NameLen; i++) name_codes_q[i] <= '0;
      for (int i = 0; i < ExtLen; i++)  ext_codes_q[i]  <= '0;
    end else begin
      phase_q      <= phase_d;
      name_cnt_q   <= name_cnt_d;
      ext_cnt_q    <= ext_cnt_d;
      name_codes_q <= name_codes_d;
      ext_codes_q  <= ext_codes_d;
    end
  end

  // Result register: load on an end byte, hold while stalled
  assign out_valid_d = (in_acc & is_end) | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_end) begin
      word_first_q  <= r50fp_pkg::pack3(name_codes_q[0], name_codes_q[1], name_codes_q[2]);
      word_second_q <= r50fp_pkg::pack3(name_codes_q[3], name_codes_q[4], name_codes_q[5]);
      word_ext_q    <= r50fp_pkg::pack3(ext_codes_q[0], ext_codes_q[1], ext_codes_q[2]);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign name_word_first_o  = word_first_q;
  assign name_word_second_o = word_second_q;
  assign ext_word_o         = word_ext_q;

  // Counters never pass their limits
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    name_cnt_q <= NcW'(NameLen) && ext_cnt_q <= EcW'(ExtLen))
    else $error("kept-character count out of range");

  // An accepted end byte always yields a result beat next cycle
  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_end |=> out_valid_q)
    else $error("end byte produced no result");

  // End or slash leaves a clean name phase
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (is_end || is_slash) |=>
      phase_q == r50fp_pkg::PH_NAME && name_cnt_q == '0 && ext_cnt_q == '0)
    else $error("state not cleared after end or slash");

  // Extension characters only exist once the name phase is left
  a_ext_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ext_cnt_q != '0 |-> phase_q != r50fp_pkg::PH_NAME)
    else $error("extension kept while still collecting name");

  // A held result is not overwritten
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(word_first_q)
      && $stable(word_second_q) && $stable(word_ext_q))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// RAD50 file-name packer testbench
// Streams path bytes into the packer and checks every packed-name beat
// against a cycle-free predictor of the last path component.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  // Three words of one packed file name
  typedef struct packed {
    r50fp_pkg::word_t first;
    r50fp_pkg::word_t second;
    r50fp_pkg::word_t ext;
  } rad50_words_t;

  localparam int unsigned PathBytes   = 750;
  localparam int unsigned TailBytes   = 80;   // last stretch runs without idling
  localparam int unsigned HangLimit   = 2000; // cycles without any beat
  localparam int unsigned DrainCycles = 4;

  logic        clk_i              = 1'b0;
  logic        rst_ni             = 1'b0;
  logic        in_valid_i         = 1'b0;
  logic [7:0]  name_byte_i        = 8'h00;
  logic        out_stall_i        = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [15:0] name_word_first_o;
  logic [15:0] name_word_second_o;
  logic [15:0] ext_word_o;

  rad50_filename_packer_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .name_byte_i        (name_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .name_word_first_o  (name_word_first_o),
    .name_word_second_o (name_word_second_o),
    .ext_word_o         (ext_word_o)
  );

  // Bytes waiting to be sent, and packed names waiting to come out
  logic [7:0]   path_bytes_q[$];
  rad50_words_t packed_names_q[$];

  int unsigned bytes_sent    = 0;
  int unsigned names_checked = 0;
  int unsigned mismatches    = 0;

  // --------------------------------------------------------------------------
  // Name predictor: its own copy of the kept characters of the current
  // component, updated once per accepted input beat.
  // --------------------------------------------------------------------------
  r50fp_pkg::phase_e kept_phase;
  logic [2:0]        kept_name_cnt;
  logic [1:0]        kept_ext_cnt;
  r50fp_pkg::code_t  kept_name [0:r50fp_pkg::NameLen-1];
  r50fp_pkg::code_t  kept_ext  [0:r50fp_pkg::ExtLen-1];

  function automatic r50fp_pkg::code_t rad50_of(input logic [7:0] b);
    logic [6:0]       c;
    r50fp_pkg::code_t r;
    c = b[6:0];
    r = r50fp_pkg::CodeOther;
    // 0xFF is the one byte whose top bit matters
    if (b == r50fp_pkg::ChAllOn || c == r50fp_pkg::ChSpace) begin
      r = r50fp_pkg::CodeSpace;
    end else if (c == r50fp_pkg::ChDollar) begin
      r = r50fp_pkg::CodeDollar;
    end else if (c == r50fp_pkg::ChDot7) begin
      r = r50fp_pkg::CodeDot;
    end else if (c >= r50fp_pkg::ChDig0 && c <= r50fp_pkg::ChDig9) begin
      r = r50fp_pkg::CodeDigit + r50fp_pkg::code_t'(c - r50fp_pkg::ChDig0);
    end else if (c >= r50fp_pkg::ChUpA && c <= r50fp_pkg::ChUpZ) begin
      r = r50fp_pkg::CodeAlpha + r50fp_pkg::code_t'(c - r50fp_pkg::ChUpA);
    end else if (c >= r50fp_pkg::ChLoA && c <= r50fp_pkg::ChLoZ) begin
      r = r50fp_pkg::CodeAlpha + r50fp_pkg::code_t'(c - r50fp_pkg::ChLoA);
    end
    return r;
  endfunction

  function automatic r50fp_pkg::word_t rad50_word(input r50fp_pkg::code_t a,
                                                  input r50fp_pkg::code_t b,
                                                  input r50fp_pkg::code_t c);
    int unsigned sum;
    sum = int'(a) * int'(r50fp_pkg::WeightA) + int'(b) * int'(r50fp_pkg::WeightB)
          + int'(c);
    return r50fp_pkg::word_t'(sum);
  endfunction

  task automatic forget_component();
    kept_phase    = r50fp_pkg::PH_NAME;
    kept_name_cnt = '0;
    kept_ext_cnt  = '0;
    foreach (kept_name[i]) kept_name[i] = r50fp_pkg::CodeSpace;
    foreach (kept_ext[i]) kept_ext[i] = r50fp_pkg::CodeSpace;
  endtask

  task automatic keep_ext_char(input logic [7:0] b);
    if (kept_ext_cnt < r50fp_pkg::ExtLen) begin
      kept_ext[kept_ext_cnt] = rad50_of(b);
      kept_ext_cnt = kept_ext_cnt + 2'd1;
    end
    if (kept_ext_cnt >= r50fp_pkg::ExtLen) kept_phase = r50fp_pkg::PH_DONE;
  endtask

  task automatic absorb_path_byte(input logic [7:0] b);
    rad50_words_t w;
    if (b == r50fp_pkg::ChEnd) begin
      w.first  = rad50_word(kept_name[0], kept_name[1], kept_name[2]);
      w.second = rad50_word(kept_name[3], kept_name[4], kept_name[5]);
      w.ext    = rad50_word(kept_ext[0], kept_ext[1], kept_ext[2]);
      packed_names_q.push_back(w);
      forget_component();
    end else if (b == r50fp_pkg::ChSlash) begin
      forget_component();
    end else begin
      case (kept_phase)
        r50fp_pkg::PH_NAME: begin
          if (kept_name_cnt == 0) begin
            // first name byte is kept even if it is a dot
            kept_name[0]  = rad50_of(b);
            kept_name_cnt = 3'd1;
          end else if (b == r50fp_pkg::ChDot) begin
            kept_phase = r50fp_pkg::PH_EXT;
          end else if (kept_name_cnt < r50fp_pkg::NameLen) begin
            kept_name[kept_name_cnt] = rad50_of(b);
            kept_name_cnt = kept_name_cnt + 3'd1;
          end else begin
            // name full: the byte opens the extension
            kept_phase = r50fp_pkg::PH_EXT;
            keep_ext_char(b);
          end
        end
        r50fp_pkg::PH_EXT: begin
          if (kept_ext_cnt != 0 && b == r50fp_pkg::ChDot) begin
            kept_phase = r50fp_pkg::PH_DONE;
          end else begin
            keep_ext_char(b);
          end
        end
        default: ;  // extension finished: ignore until slash or end
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  // Any byte that the packer keeps as a character (never end, slash or dot)
  function automatic logic [7:0] path_char();
    logic [7:0] b;
    case ($urandom_range(0, 9))
      0, 1, 2: b = r50fp_pkg::ChUpA + 8'($urandom_range(0, 25));
      3, 4:    b = r50fp_pkg::ChLoA + 8'($urandom_range(0, 25));
      5:       b = r50fp_pkg::ChDig0 + 8'($urandom_range(0, 9));
      6:       b = $urandom_range(0, 1) ? {1'b0, r50fp_pkg::ChDollar}
                                        : {1'b0, r50fp_pkg::ChSpace};
      7:       b = 8'h80 | 8'($urandom_range(0, 127));
      default: b = 8'($urandom_range(1, 255));
    endcase
    if (b == r50fp_pkg::ChEnd || b == r50fp_pkg::ChSlash || b == r50fp_pkg::ChDot) begin
      b = r50fp_pkg::ChAllOn;
    end
    return b;
  endfunction

  // Well-formed path: optional directories, a name, maybe an extension, end
  task automatic queue_path();
    int dirs;
    int name_len;
    dirs     = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    name_len = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 9) : $urandom_range(1, 6);
    repeat (dirs) begin
      repeat ($urandom_range(1, 4)) path_bytes_q.push_back(path_char());
      path_bytes_q.push_back(r50fp_pkg::ChSlash);
    end
    for (int i = 0; i < name_len; i++) begin
      path_bytes_q.push_back((i == 0 && $urandom_range(0, 9) == 0) ? r50fp_pkg::ChDot
                                                                    : path_char());
    end
    if ($urandom_range(0, 3) != 0) begin
      path_bytes_q.push_back(r50fp_pkg::ChDot);
      repeat ($urandom_range(0, 5)) begin
        path_bytes_q.push_back(($urandom_range(0, 7) == 0) ? r50fp_pkg::ChDot
                                                            : path_char());
      end
    end
    path_bytes_q.push_back(r50fp_pkg::ChEnd);
  endtask

  // Broken sequence: raw bytes with the separators overweighted
  task automatic queue_noise();
    repeat ($urandom_range(1, 12)) begin
      case ($urandom_range(0, 5))
        0:       path_bytes_q.push_back(r50fp_pkg::ChSlash);
        1:       path_bytes_q.push_back(r50fp_pkg::ChDot);
        2:       path_bytes_q.push_back(r50fp_pkg::ChEnd);
        default: path_bytes_q.push_back(8'($urandom));
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock and stimulus / end-of-run control
  // --------------------------------------------------------------------------
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    logic [7:0] directed [20];
    directed = '{
      r50fp_pkg::ChEnd,                         // empty name
      r50fp_pkg::ChDot, r50fp_pkg::ChDot,       // leading dot kept twice,
      r50fp_pkg::ChDot, r50fp_pkg::ChDot,       // then done
      r50fp_pkg::ChEnd,
      r50fp_pkg::ChAllOn, 8'h7F,                // slash drops the first bytes
      r50fp_pkg::ChSlash,
      8'h80, 8'h7A, 8'h39, 8'h20, 8'h24, 8'h51, // six name chars
      r50fp_pkg::ChDot, 8'h47,                  // dot on full name,
      r50fp_pkg::ChDot, 8'h4A,                  // ext ended by dot
      r50fp_pkg::ChEnd
    };
    foreach (directed[i]) path_bytes_q.push_back(directed[i]);
    while (path_bytes_q.size() < PathBytes + $size(directed)) begin
      if ($urandom_range(0, 4) == 0) begin
        queue_noise();
      end else begin
        queue_path();
      end
    end
    // flush whatever the last noise left behind
    path_bytes_q.push_back(r50fp_pkg::ChEnd);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the last byte to go in and the last name to come out
    do @(posedge clk_i);
    while (path_bytes_q.size() != 0 || in_valid_i || packed_names_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d path bytes, checked %0d packed names, %0d mismatches.",
             bytes_sent, names_checked, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver: feed path bytes, insert idle bursts on the input and stall
  // bursts on the output. Every signal gets at most one assignment per edge.
  // --------------------------------------------------------------------------
  int unsigned in_gap    = 0;
  int unsigned out_gap   = 0;
  int unsigned cyc_count = 0;
  bit          calm      = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    bit         quiet;
    bit         next_valid;
    logic [7:0] next_byte;
    if (!rst_ni) begin
      forget_component();
      in_valid_i  <= 1'b0;
      name_byte_i <= 8'h00;
      out_stall_i <= 1'b0;
    end else begin
      // Predict on the accepted beat, then advance the byte queue
      if (in_valid_i && !in_stall_o) begin
        absorb_path_byte(name_byte_i);
        void'(path_bytes_q.pop_front());
        bytes_sent++;
      end

      // Switch between busy and calm stretches now and then
      cyc_count++;
      if (cyc_count % 64 == 0) calm = ($urandom_range(0, 2) == 0);
      quiet = calm || (path_bytes_q.size() < TailBytes);

      // Hold a stalled beat; otherwise pick the next beat or an idle cycle
      if (!(in_valid_i && in_stall_o)) begin
        next_valid = 1'b0;
        next_byte  = name_byte_i;
        if (in_gap > 0) begin
          in_gap--;
        end else if (path_bytes_q.size() > 0) begin
          if (!quiet && $urandom_range(0, 9) == 0) begin
            in_gap = $urandom_range(1, 15) - 1;
          end else begin
            next_valid = 1'b1;
            next_byte  = path_bytes_q[0];
          end
        end
        in_valid_i  <= next_valid;
        name_byte_i <= next_byte;
      end

      // Output stall bursts, independent of whether a result is waiting
      if (out_gap > 0) begin
        out_gap--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(1, 15);
      end
      out_stall_i <= (out_gap > 0);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each result beat with the oldest predicted name, and
  // watch for a hang.
  // --------------------------------------------------------------------------
  int unsigned hang_cycles = 0;

  always @(posedge clk_i) begin
    rad50_words_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (packed_names_q.size() == 0) begin
          $display("%0t: result beat expected none, actual first %0d second %0d ext %0d",
                   $time, name_word_first_o, name_word_second_o, ext_word_o);
          mismatches++;
        end else begin
          want = packed_names_q.pop_front();
          names_checked++;
          if (name_word_first_o !== want.first) begin
            $display("%0t: name_word_first expected %0d actual %0d",
                     $time, want.first, name_word_first_o);
            mismatches++;
          end
          if (name_word_second_o !== want.second) begin
            $display("%0t: name_word_second expected %0d actual %0d",
                     $time, want.second, name_word_second_o);
            mismatches++;
          end
          if (ext_word_o !== want.ext) begin
            $display("%0t: ext_word expected %0d actual %0d",
                     $time, want.ext, ext_word_o);
            mismatches++;
          end
        end
      end

      // Any beat on either side counts as progress
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        hang_cycles = 0;
      end else begin
        hang_cycles++;
      end
      if (hang_cycles >= HangLimit) begin
        $display("%0t: no beat for %0d cycles, %0d names still expected",
                 $time, HangLimit, packed_names_q.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
